### hw/rtl/aosl_pkg.sv
`default_nettype none
package aosl_pkg;

  localparam int unsigned MAX_SWITCHES = 32;
  localparam int unsigned IDX_W        = $clog2(MAX_SWITCHES);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned MASK_W       = MAX_SWITCHES;
  localparam int unsigned PIX_W        = 12;
  localparam int unsigned COORD_W      = 22;
  localparam int unsigned PROD_W       = CNT_W + PIX_W;
  localparam int unsigned POS_W        = 20;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned TDATA_W      = 32;
  localparam int unsigned TUSER_W      = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN_MODE   = 3'd0,
    CFG_SWITCH_COUNT = 3'd1,
    CFG_ORIGIN_X     = 3'd2,
    CFG_ORIGIN_Y     = 3'd3,
    CFG_AREA_WIDTH   = 3'd4,
    CFG_AREA_HEIGHT  = 3'd5,
    CFG_ICON_WIDTH   = 3'd6,
    CFG_ICON_HEIGHT  = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRD,
    S_CCHK,
    S_ASTART,
    S_APP,
    S_ERD,
    S_EMUL,
    S_ECALC,
    S_OUT
  } aosl_state_t;

  typedef struct packed {
    logic load;       // take a new mask
    logic crd;        // read list entry for compaction
    logic keep;       // keep entry if its bit is still set
    logic app_start;  // commit compacted count, restart scan
    logic app_step;   // test one bit for a rising edge and append
    logic erd;        // read list entry for a result
    logic mul;        // form slot (plus one for right/down) times icon size
    logic out_load;   // build the result register
    logic idx_inc;    // advance to next slot
    logic idx_clr;    // rewind the walk index
  } aosl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic compact_last;
    logic scan_last;
    logic emit_last;
  } aosl_sts_t;

endpackage
`default_nettype wire

### hw/rtl/aosl_ctrl.sv
`default_nettype none
module aosl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire aosl_pkg::aosl_sts_t sts,
  output aosl_pkg::aosl_cmd_t     cmd
);
  import aosl_pkg::*;

  aosl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = sts.count_zero ? S_ASTART : S_CRD;
      end
      S_CRD:    state_nxt = S_CCHK;
      S_CCHK:   state_nxt = sts.compact_last ? S_ASTART : S_CRD;
      S_ASTART: state_nxt = S_APP;
      S_APP: begin
        if (sts.scan_last) state_nxt = S_ERD;
      end
      S_ERD:    state_nxt = S_EMUL;
      S_EMUL:   state_nxt = S_ECALC;
      S_ECALC:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = sts.emit_last ? S_IDLE : S_ERD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_CRD:    cmd.crd = 1'b1;
      S_CCHK:   cmd.keep = 1'b1;
      S_ASTART: cmd.app_start = 1'b1;
      S_APP: begin
        cmd.app_step = 1'b1;
        cmd.idx_clr  = sts.scan_last;
      end
      S_ERD:    cmd.erd = 1'b1;
      S_EMUL:   cmd.mul = 1'b1;
      S_ECALC:  cmd.out_load = 1'b1;
      S_OUT: begin
        out_tvalid  = 1'b1;
        cmd.idx_inc = out_tready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/aosl_dp.sv
`default_nettype none
module aosl_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [aosl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aosl_pkg::PIX_W-1:0]           cfg_data,
  input  wire logic [aosl_pkg::MASK_W-1:0]          in_mask,
  input  wire aosl_pkg::aosl_cmd_t                  cmd,
  output aosl_pkg::aosl_sts_t                       sts,
  output logic                                      entry_valid,
  output logic [aosl_pkg::IDX_W-1:0]                slot_position,
  output logic [aosl_pkg::IDX_W-1:0]                switch_index,
  output logic                                      axis_is_y,
  output logic signed [aosl_pkg::COORD_W-1:0]       coordinate,
  output logic                                      mask_changed,
  output logic                                      last_result
);
  import aosl_pkg::*;

  // configuration registers
  logic [1:0]              align_mode_r;
  logic [CNT_W-1:0]        switch_count_r;
  logic signed [PIX_W-1:0] origin_x_r, origin_y_r;
  logic [PIX_W-1:0]        area_width_r, area_height_r, icon_width_r, icon_height_r;

  // list state
  logic [IDX_W-1:0]  mem [MAX_SWITCHES];
  logic [IDX_W-1:0]  rd_data_r;
  logic [CNT_W-1:0]  order_count_r;
  logic [MASK_W-1:0] prev_mask_r;
  logic              prev_valid_r;

  // per-item working registers
  logic [MASK_W-1:0] mask_r, old_r;
  logic [CNT_W-1:0]  limit_r;
  logic              changed_r;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  kept_r;
  logic [IDX_W-1:0]  sw_r;
  logic [PROD_W-1:0] prod_r;

  // output register
  logic                      ev_r, axis_r, chg_r, last_r;
  logic [IDX_W-1:0]          slot_r, swo_r;
  logic signed [COORD_W-1:0] coord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_mode_r   <= '0;
      switch_count_r <= CNT_W'(MAX_SWITCHES);
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      area_width_r   <= PIX_W'(1);
      area_height_r  <= PIX_W'(1);
      icon_width_r   <= '0;
      icon_height_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALIGN_MODE:   align_mode_r   <= cfg_data[1:0];
        CFG_SWITCH_COUNT: switch_count_r <= cfg_data[CNT_W-1:0];
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        CFG_AREA_WIDTH:   area_width_r   <= cfg_data;
        CFG_AREA_HEIGHT:  area_height_r  <= cfg_data;
        CFG_ICON_WIDTH:   icon_width_r   <= cfg_data;
        CFG_ICON_HEIGHT:  icon_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // list memory: one write port, one registered read port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, wr_data;
  logic             rising;

  assign rising = mask_r[idx_r[IDX_W-1:0]] & ~old_r[idx_r[IDX_W-1:0]] & (idx_r < limit_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = kept_r[IDX_W-1:0];
    wr_data = rd_data_r;
    if (cmd.keep) begin
      wr_en = mask_r[rd_data_r];
    end else if (cmd.app_step) begin
      wr_en   = rising && (order_count_r < CNT_W'(MAX_SWITCHES));
      wr_addr = order_count_r[IDX_W-1:0];
      wr_data = idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.crd || cmd.erd) rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_count_r <= '0;
      prev_mask_r   <= '0;
      prev_valid_r  <= 1'b0;
      idx_r         <= '0;
      kept_r        <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.load) begin
        prev_mask_r  <= in_mask;
        prev_valid_r <= 1'b1;
        kept_r       <= '0;
      end
      if (cmd.keep && mask_r[rd_data_r]) kept_r <= kept_r + 1'b1;
      if (cmd.app_start) order_count_r <= kept_r;
      if (wr_en && cmd.app_step) order_count_r <= order_count_r + 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load || cmd.app_start || cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.keep || cmd.app_step || cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r    <= in_mask;
      old_r     <= prev_mask_r;
      changed_r <= !prev_valid_r || (prev_mask_r != in_mask);
      limit_r   <= (switch_count_r > CNT_W'(MAX_SWITCHES)) ? CNT_W'(MAX_SWITCHES)
                                                           : switch_count_r;
    end
  end

  // coordinate: slot (plus one for right or down) times icon size, then offset and saturate
  logic [CNT_W-1:0]        factor;
  logic [PIX_W-1:0]        icon_sel;
  logic signed [POS_W-1:0] base, pos;
  logic [COORD_W-1:0]      coord_sat;

  assign factor   = {1'b0, idx_r[IDX_W-1:0]} + CNT_W'(align_mode_r[0]);
  assign icon_sel = align_mode_r[1] ? icon_height_r : icon_width_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(factor) * PROD_W'(icon_sel);
      sw_r   <= rd_data_r;
    end
  end

  always_comb begin
    case (align_mode_r)
      2'd0:    base = POS_W'(origin_x_r);
      2'd1:    base = POS_W'(origin_x_r) + POS_W'({1'b0, area_width_r});
      2'd2:    base = POS_W'(origin_y_r);
      default: base = POS_W'(origin_y_r) + POS_W'({1'b0, area_height_r});
    endcase
    if (align_mode_r[0]) pos = base - POS_W'(prod_r);
    else                 pos = base + POS_W'(prod_r);
    // in range when the top bits agree with the sign of an 18-bit value
    if (pos[POS_W-1:COORD_W-5] == '0 || pos[POS_W-1:COORD_W-5] == '1) begin
      coord_sat = {pos[COORD_W-5:0], 4'b0000};
    end else if (pos[POS_W-1]) begin
      coord_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      coord_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ev_r    <= !sts.count_zero;
      slot_r  <= sts.count_zero ? '0 : idx_r[IDX_W-1:0];
      swo_r   <= sts.count_zero ? '0 : sw_r;
      coord_r <= sts.count_zero ? '0 : coord_sat;
      axis_r  <= align_mode_r[1];
      chg_r   <= changed_r;
      last_r  <= sts.emit_last;
    end
  end

  assign sts.count_zero   = (order_count_r == '0);
  assign sts.compact_last = (idx_r + 1'b1 == order_count_r);
  assign sts.scan_last    = (idx_r == CNT_W'(MAX_SWITCHES - 1));
  assign sts.emit_last    = (order_count_r == '0) || (idx_r + 1'b1 == order_count_r);

  assign entry_valid   = ev_r;
  assign slot_position = slot_r;
  assign switch_index  = swo_r;
  assign axis_is_y     = axis_r;
  assign coordinate    = coord_r;
  assign mask_changed  = chg_r;
  assign last_result   = last_r;

endmodule
`default_nettype wire

### hw/rtl/activation_order_switch_layout.sv
// Activation-order switch layout.
//
// The in_ stream carries one request per switch mask (in_tdata bit i set means
// switch i is on). The block keeps the on switches in the order they came on,
// drops entries whose bit fell, appends newly risen indices below the switch
// count in ascending order and then returns one out_ request per listed entry
// with its icon offset in 1/16-pixel units. An empty list returns one request
// with entry_valid low. out_tlast marks the final request for a mask.
// Flow: a mask is taken only while the block is idle. Work on it runs a
// compaction pass over the entries listed before (one memory read and one
// check each), a setup step, a scan over every mask bit for appends (one
// bit per cycle), then for each result a memory read, a multiply, offset
// and saturate, and presenting the result.
// The cfg_ port is always ready; write it only while the block is idle.
// Reset (rst_n low, synchronous) forgets the previous mask, empties the list
// and loads the register defaults. A stalled receiver simply holds the
// current result in the output register until out_tready rises.
`default_nettype none
module activation_order_switch_layout (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: [31:0] switch_mask
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [aosl_pkg::TDATA_W-1:0]        in_tdata,
  // out_tdata: [4:0] slot_position, [9:5] switch_index, [31:10] coordinate
  // out_tuser: [0] entry_valid, [1] axis_is_y, [2] mask_changed
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [aosl_pkg::TDATA_W-1:0]             out_tdata,
  output logic [aosl_pkg::TUSER_W-1:0]             out_tuser,
  output logic                                     out_tlast,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [aosl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [aosl_pkg::PIX_W-1:0]          cfg_data
);
  import aosl_pkg::*;

  aosl_cmd_t cmd;
  aosl_sts_t sts;

  logic                      entry_valid, axis_is_y, mask_changed, last_result;
  logic [IDX_W-1:0]          slot_position, switch_index;
  logic signed [COORD_W-1:0] coordinate;

  // configuration writes never stall
  assign cfg_ready = 1'b1;

  aosl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aosl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mask       (in_tdata[MASK_W-1:0]),
    .cmd           (cmd),
    .sts           (sts),
    .entry_valid   (entry_valid),
    .slot_position (slot_position),
    .switch_index  (switch_index),
    .axis_is_y     (axis_is_y),
    .coordinate    (coordinate),
    .mask_changed  (mask_changed),
    .last_result   (last_result)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {coordinate, switch_index, slot_position};
  assign out_tuser = {mask_changed, axis_is_y, entry_valid};
  assign out_tlast = last_result;

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import aosl_pkg::*;

  // Allow the longest quiet stretch of a correct run several times over:
  // a 32-entry compaction, the 32-bit scan, a result pipeline and a stall.
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES     = 150;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned MASKS_PER_PHASE = 43;
  localparam longint      SUBPIX          = 16;
  localparam longint      COORD_TOP       = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint      COORD_BOTTOM    = -(longint'(1) << (COORD_W - 1));

  // Alignment codes of the align_mode register
  localparam bit [1:0] ALIGN_LEFT  = 2'd0;
  localparam bit [1:0] ALIGN_RIGHT = 2'd1;
  localparam bit [1:0] ALIGN_UP    = 2'd2;
  localparam bit [1:0] ALIGN_DOWN  = 2'd3;

  // One placed icon as carried by an out_ request
  typedef struct packed {
    logic               ev;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   sw;
    logic               axis;
    logic [COORD_W-1:0] coord;
    logic               chg;
    logic               last;
  } icon_req_t;

  typedef enum bit { ROW_MASK, ROW_REG } row_kind_t;

  // Directed stimulus row: a register write or a mask, optionally with the
  // single request it must produce typed in.
  typedef struct packed {
    row_kind_t            kind;
    cfg_idx_t             idx;
    bit [PIX_W-1:0]       val;
    bit [MASK_W-1:0]      mask;
    bit                   known;
    bit [TDATA_W-1:0]     known_data;
    bit [TUSER_W-1:0]     known_user;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [TDATA_W-1:0]   out_tdata;
  logic [TUSER_W-1:0]   out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [PIX_W-1:0]     cfg_data   = '0;

  activation_order_switch_layout u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Layout predictor: own copy of the activation list and the registers
  // ---------------------------------------------------------------------
  bit [IDX_W-1:0]        order_q [MAX_SWITCHES];
  int unsigned           order_n;
  bit [MASK_W-1:0]       seen_mask;
  bit                    seen_any;
  bit [1:0]              r_align;
  bit [5:0]              r_count;
  bit signed [PIX_W-1:0] r_ox, r_oy;
  bit [PIX_W-1:0]        r_aw, r_ah, r_iw, r_ih;

  icon_req_t layout_q[$];  // expected out_ requests, oldest first
  icon_req_t fresh_q[$];   // requests of the mask just predicted

  bit          gaps_on;
  int unsigned bad_cnt;

  function automatic void reset_mirror();
    r_align   = ALIGN_LEFT;
    r_count   = 6'd32;
    r_ox      = '0;
    r_oy      = '0;
    r_aw      = 12'd1;
    r_ah      = 12'd1;
    r_iw      = '0;
    r_ih      = '0;
    order_n   = 0;
    seen_mask = '0;
    seen_any  = 1'b0;
  endfunction

  function automatic void mirror_reg(cfg_idx_t idx, bit [PIX_W-1:0] v);
    case (idx)
      CFG_ALIGN_MODE:   r_align = v[1:0];
      CFG_SWITCH_COUNT: r_count = v[5:0];
      CFG_ORIGIN_X:     r_ox    = v;
      CFG_ORIGIN_Y:     r_oy    = v;
      CFG_AREA_WIDTH:   r_aw    = v;
      CFG_AREA_HEIGHT:  r_ah    = v;
      CFG_ICON_WIDTH:   r_iw    = v;
      CFG_ICON_HEIGHT:  r_ih    = v;
      default: ;
    endcase
  endfunction

  // Offset of slot k in 1/16 pixels, saturated to the coordinate range
  function automatic bit [COORD_W-1:0] icon_offset(int unsigned k);
    longint kk, ox, oy, aw, ah, iw, ih, p;
    kk = k;
    ox = r_ox;
    oy = r_oy;
    aw = r_aw;
    ah = r_ah;
    iw = r_iw;
    ih = r_ih;
    case (r_align)
      ALIGN_LEFT:  p = ox + kk * iw;
      ALIGN_RIGHT: p = ox + aw - (kk + 1) * iw;
      ALIGN_UP:    p = oy + kk * ih;
      default:     p = oy + ah - (kk + 1) * ih;
    endcase
    p = p * SUBPIX;
    if (p > COORD_TOP) p = COORD_TOP;
    if (p < COORD_BOTTOM) p = COORD_BOTTOM;
    return p[COORD_W-1:0];
  endfunction

  // Advance the list for one mask and leave its requests in fresh_q
  function automatic void predict_layout(bit [MASK_W-1:0] mask);
    bit [MASK_W-1:0] old;
    int unsigned     lim, kept;
    bit              chg, axis;
    icon_req_t       r;
    fresh_q.delete();
    old  = seen_any ? seen_mask : '0;
    lim  = (r_count > MAX_SWITCHES) ? MAX_SWITCHES : r_count;
    chg  = !seen_any || (old != mask);
    axis = r_align[1];
    // drop entries whose switch went off, keep the order of the rest
    kept = 0;
    for (int i = 0; i < order_n; i++) begin
      if (mask[order_q[i]]) begin
        order_q[kept] = order_q[i];
        kept++;
      end
    end
    order_n = kept;
    // append rising switches below the count, lowest index first
    for (int i = 0; i < lim; i++) begin
      if (mask[i] && !old[i] && order_n < MAX_SWITCHES) begin
        order_q[order_n] = IDX_W'(i);
        order_n++;
      end
    end
    seen_mask = mask;
    seen_any  = 1'b1;
    if (order_n == 0) begin
      r      = '0;
      r.axis = axis;
      r.chg  = chg;
      r.last = 1'b1;
      fresh_q.push_back(r);
    end else begin
      for (int k = 0; k < order_n; k++) begin
        r.ev    = 1'b1;
        r.slot  = IDX_W'(k);
        r.sw    = order_q[k];
        r.axis  = axis;
        r.coord = icon_offset(k);
        r.chg   = chg;
        r.last  = (k + 1 == order_n);
        fresh_q.push_back(r);
      end
    end
  endfunction

  function automatic icon_req_t unpack_req(logic [TDATA_W-1:0] d, logic [TUSER_W-1:0] u,
                                           logic l);
    icon_req_t r;
    r.slot  = d[IDX_W-1:0];
    r.sw    = d[2*IDX_W-1:IDX_W];
    r.coord = d[2*IDX_W +: COORD_W];
    r.ev    = u[0];
    r.axis  = u[1];
    r.chg   = u[2];
    r.last  = l;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one mask request, hold it until accepted, then book its results.
  // Leave in_tvalid high so back-to-back requests need no toggle.
  task automatic send_mask(bit [MASK_W-1:0] m, bit known, bit [TDATA_W-1:0] kd,
                           bit [TUSER_W-1:0] ku);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_layout(m);
    if (known) begin
      layout_q.push_back(unpack_req(kd, ku, 1'b1));
    end else begin
      foreach (fresh_q[j]) layout_q.push_back(fresh_q[j]);
    end
  endtask

  // Write one register; leave cfg_valid high for a following write
  task automatic write_reg(cfg_idx_t idx, bit [PIX_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    mirror_reg(idx, v);
  endtask

  // Drop both request lines and wait until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (layout_q.size() != 0);
  endtask

  // Register value for a random phase: phase 0 pushes the upper extremes,
  // phase 1 the lower ones, later phases mix small sizes with full range.
  function automatic bit [PIX_W-1:0] pick_reg(cfg_idx_t idx, int unsigned p);
    bit [PIX_W-1:0] v;
    bit [5:0]       cnt;
    v = PIX_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0:       cnt = 6'd0;
      1:       cnt = 6'($urandom_range(33, 63));
      default: cnt = 6'($urandom_range(1, 32));
    endcase
    case (idx)
      CFG_ALIGN_MODE:
        v = (p == 0) ? PIX_W'(ALIGN_DOWN) : (p == 1) ? PIX_W'(ALIGN_LEFT) : v;
      CFG_SWITCH_COUNT:
        v = (p == 0) ? PIX_W'(32) : (p == 1) ? PIX_W'(1) : {v[PIX_W-1:6], cnt};
      CFG_ORIGIN_X, CFG_ORIGIN_Y:
        v = (p == 0) ? 12'h7FF : (p == 1) ? 12'h800 : v;
      default: begin
        if (p == 0) v = '1;
        else if (p == 1) v = '0;
        else if ($urandom_range(0, 3) != 0) v = PIX_W'($urandom_range(0, 64));
      end
    endcase
    return v;
  endfunction

  // Mostly flip a few switches of the last mask so the list keeps a
  // history; sometimes clear all, set all, repeat, or throw noise.
  function automatic bit [MASK_W-1:0] next_mask(bit [MASK_W-1:0] prev);
    bit [MASK_W-1:0] m;
    int unsigned     b;
    m = prev;
    case ($urandom_range(0, 15))
      0:       m = '0;
      1:       m = '1;
      2:       ;
      3, 4:    m = $urandom;
      default: begin
        repeat ($urandom_range(1, 3)) begin
          b    = $urandom_range(0, MASK_W - 1);
          m[b] = ~m[b];
        end
      end
    endcase
    return m;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts while gaps are on
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Checker: compare each accepted out_ request with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    icon_req_t got, want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = unpack_req(out_tdata, out_tuser, out_tlast);
      if (layout_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $write("%0t: unexpected request ev=%0d slot=%0d sw=%0d y=%0d",
                 $realtime, got.ev, got.slot, got.sw, got.axis);
          $display(" coord=%0d chg=%0d last=%0d", $signed(got.coord), got.chg, got.last);
        end
      end else begin
        want = layout_q.pop_front();
        if (got.ev !== want.ev || got.slot !== want.slot || got.sw !== want.sw ||
            got.axis !== want.axis || got.coord !== want.coord ||
            got.chg !== want.chg || got.last !== want.last) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $write("%0t: mismatch exp ev=%0d slot=%0d sw=%0d y=%0d coord=%0d chg=%0d last=%0d",
                   $realtime, want.ev, want.slot, want.sw, want.axis, $signed(want.coord),
                   want.chg, want.last);
            $display(" / got ev=%0d slot=%0d sw=%0d y=%0d coord=%0d chg=%0d last=%0d",
                     got.ev, got.slot, got.sw, got.axis, $signed(got.coord), got.chg,
                     got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: end the run after too many cycles without any handshake
  // ---------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    plan_row_t       plan[$];
    row_kind_t       prev_kind;
    bit [MASK_W-1:0] m;
    cfg_idx_t        idx;

    reset_mirror();
    gaps_on = 1'b1;
    bad_cnt = 0;

    // Directed part. known_user is {mask_changed, axis_is_y, entry_valid}.
    // empty list after reset: one request, changed
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_0000, 1'b1, 32'h0, 3'b100});
    // same empty mask again: no change
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_0000, 1'b1, 32'h0, 3'b000});
    // first switch at the origin with zero-size icons
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_0001, 1'b1, 32'h0, 3'b101});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h8000_0001, 1'b0, 32'h0, 3'b000});
    // fill the whole list, then repeat it unchanged
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ORIGIN_X, 12'h7FF, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ICON_WIDTH, 12'hFFF, 32'h0, 1'b0, 32'h0, 3'b000});
    // drop every other switch, then invert the mask
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h5555_5554, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hAAAA_AAAB, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ALIGN_MODE, {10'd0, ALIGN_RIGHT}, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_AREA_WIDTH, 12'hFFF, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b0, 32'h0, 3'b000});
    // down alignment from the lowest origin with the largest icon height
    plan.push_back('{ROW_REG, CFG_ALIGN_MODE, {10'd0, ALIGN_DOWN}, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ORIGIN_Y, 12'h800, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_AREA_HEIGHT, 12'h001, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ICON_HEIGHT, 12'hFFF, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h7FFF_FFFF, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ALIGN_MODE, {10'd0, ALIGN_UP}, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b0, 32'h0, 3'b000});
    // empty list on the y axis
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_0000, 1'b1, 32'h0, 3'b110});
    // zero switch count (upper data bits set): nothing is appended
    plan.push_back('{ROW_REG, CFG_ALIGN_MODE, {10'd0, ALIGN_LEFT}, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_SWITCH_COUNT, 12'hFC0, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b1, 32'h0, 3'b100});
    // four switches in use: bits above the count never join the list
    plan.push_back('{ROW_REG, CFG_SWITCH_COUNT, 12'h004, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFFF_FFFF, 1'b1, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_00F0, 1'b1, 32'h0, 3'b100});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_00FF, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'hFFF0_000A, 1'b0, 32'h0, 3'b000});
    // count above the maximum acts as the maximum
    plan.push_back('{ROW_REG, CFG_SWITCH_COUNT, 12'h021, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h8000_000A, 1'b0, 32'h0, 3'b000});
    // listed entries above a shrunken count stay while their bit is set
    plan.push_back('{ROW_REG, CFG_SWITCH_COUNT, 12'h001, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h8000_000B, 1'b0, 32'h0, 3'b000});
    // right alignment from the far left with zero sizes
    plan.push_back('{ROW_REG, CFG_SWITCH_COUNT, 12'h03F, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ALIGN_MODE, {10'd0, ALIGN_RIGHT}, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ORIGIN_X, 12'h800, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_AREA_WIDTH, 12'h000, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_REG, CFG_ICON_WIDTH, 12'h000, 32'h0, 1'b0, 32'h0, 3'b000});
    plan.push_back('{ROW_MASK, CFG_ALIGN_MODE, 12'h000, 32'h0000_0001, 1'b0, 32'h0, 3'b000});

    // hold reset, then release it for good
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table. Register rows wait for the block to go idle first.
    prev_kind = ROW_MASK;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (prev_kind == ROW_MASK) drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (prev_kind == ROW_REG) cfg_valid <= 1'b0;
        send_mask(plan[i].mask, plan[i].known, plan[i].known_data, plan[i].known_user);
      end
      prev_kind = plan[i].kind;
    end

    // Random phases: rewrite every register while idle, then stream masks.
    // Phase 3 and the last two phases run without idle bursts.
    m = seen_mask;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      idx = idx.first();
      do begin
        write_reg(idx, pick_reg(idx, p));
        idx = idx.next();
      end while (idx != idx.first());
      cfg_valid <= 1'b0;
      gaps_on = (p < RANDOM_PHASES - 2) && (p != 3);
      for (int n = 0; n < MASKS_PER_PHASE; n++) begin
        m = next_mask(m);
        send_mask(m, 1'b0, '0, '0);
      end
    end

    // Wait out every expected request, then a tail for stray ones
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
